// ===== hw/rtl/ffd_pkg.sv =====
`timescale 1ns / 1ps

package ffd_pkg;

  // sample and field widths
  localparam int SAMPLE_W  = 24;
  localparam int DMS_W     = 24;
  localparam int SPM_W     = 16;
  localparam int GAIN_W    = 16;
  localparam int LEN_CFG_W = 17;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 24;

  // delay in samples: Q24.16
  localparam int FRAC_W = 16;
  localparam int D_W    = DMS_W + SPM_W;
  localparam int HI_W   = D_W - FRAC_W;

  // remainder unit: two quotient bits per cycle
  localparam int DIV_STEPS = HI_W / 2;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  localparam int GAIN_FRAC = 14;

  localparam logic [SPM_W-1:0] SPM_RST = 16'd11290;

  // register indexes
  localparam logic [CFG_AW-1:0] REG_DELAY_MS  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_SPM       = 3'd1;
  localparam logic [CFG_AW-1:0] REG_LENGTH    = 3'd2;
  localparam logic [CFG_AW-1:0] REG_GAIN      = 3'd3;
  localparam logic [CFG_AW-1:0] REG_DELAY_SEL = 3'd4;
  localparam logic [CFG_AW-1:0] REG_FB_SEL    = 3'd5;

endpackage

// ===== hw/rtl/ffd_rem.sv =====
`timescale 1ns / 1ps

module ffd_rem #(
  parameter int LW = 17
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ffd_pkg::HI_W-1:0]    dividend,
  input  logic [LW-1:0]               divisor,
  output logic                        done,
  output logic [LW-1:0]               rem
);

  logic [ffd_pkg::HI_W-1:0]   dvd_r;
  logic [LW-1:0]              rem_r;
  logic [ffd_pkg::DIV_CW-1:0] cnt_r;
  logic                       busy_r;
  logic                       done_r;

  logic [LW:0] r1;
  logic [LW:0] r1_sub;
  logic [LW:0] r2;
  logic [LW:0] r2_sub;

  // restoring remainder, two dividend bits per cycle
  always_comb begin
    r1     = {rem_r, dvd_r[ffd_pkg::HI_W-1]};
    r1_sub = (r1 >= {1'b0, divisor}) ? r1 - {1'b0, divisor} : r1;
    r2     = {r1_sub[LW-1:0], dvd_r[ffd_pkg::HI_W-2]};
    r2_sub = (r2 >= {1'b0, divisor}) ? r2 - {1'b0, divisor} : r2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == ffd_pkg::DIV_CW'(ffd_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[ffd_pkg::HI_W-3:0], 2'b00};
      rem_r <= r2_sub[LW-1:0];
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ===== hw/rtl/ffd_mem.sv =====
`timescale 1ns / 1ps

module ffd_mem #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [AW-1:0]                     rd_addr,
  output logic signed [ffd_pkg::SAMPLE_W-1:0] rd_data,
  input  logic                              wr_en,
  input  logic [AW-1:0]                     wr_addr,
  input  logic signed [ffd_pkg::SAMPLE_W-1:0] wr_data
);

  logic signed [ffd_pkg::SAMPLE_W-1:0] mem [DEPTH];
  logic signed [ffd_pkg::SAMPLE_W-1:0] rd_data_r;
  logic                                rd_ok_r;
  // writes fill the memory from slot zero upward, so everything at or
  // above this count has not been written yet and reads as zero
  logic [AW:0]                         fill_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
    rd_ok_r   <= ({1'b0, rd_addr} < fill_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (wr_en && ({1'b0, wr_addr} >= fill_r)) begin
      fill_r <= {1'b0, wr_addr} + 1'b1;
    end
  end

  assign rd_data = rd_ok_r ? rd_data_r : '0;

endmodule

// ===== hw/rtl/fractional_feedback_delay_core.sv =====
`timescale 1ns / 1ps
// One sample at a time: in_stall is high from accept until the result is loaded.
// After accept the sample runs through S_DLY, S_ADR, S_RDB, S_INT, S_MIX, S_FB, S_WR and
// S_OUT. The delay is clamped when it comes from the input and the gain from the register;
// otherwise S_DIV waits between S_DLY and S_ADR for the remainder unit that wraps the delay
// into the line length in 12 two-bit steps. There is no memory clearing pass.
// Synchronous active-low reset: config to defaults, write index and fill count to 0.
module fractional_feedback_delay_core #(
  parameter int MAX_DELAY = 65536
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [ffd_pkg::SAMPLE_W-1:0] in_sample,
  input  logic signed [ffd_pkg::DMS_W-1:0]    in_delay_ms_in,
  input  logic signed [ffd_pkg::GAIN_W-1:0]   in_feedback_in,
  input  logic                                in_block_end,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ffd_pkg::SAMPLE_W-1:0] out_sample,
  input  logic                                cfg_wr_en,
  input  logic [ffd_pkg::CFG_AW-1:0]          cfg_addr,
  input  logic [ffd_pkg::CFG_DW-1:0]          cfg_wdata
);

  localparam int AW      = $clog2(MAX_DELAY);
  localparam int LW      = $clog2(MAX_DELAY + 1);
  localparam int LEN_RST = (MAX_DELAY < 65536) ? MAX_DELAY : 65536;
  localparam int SW      = ffd_pkg::SAMPLE_W;
  localparam int PW      = ffd_pkg::FRAC_W + SW + 2;
  localparam int GPW     = SW + ffd_pkg::GAIN_W;

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_DLY  = 10'b00_0000_0010,
    S_DIV  = 10'b00_0000_0100,
    S_ADR  = 10'b00_0000_1000,
    S_RDB  = 10'b00_0001_0000,
    S_INT  = 10'b00_0010_0000,
    S_MIX  = 10'b00_0100_0000,
    S_FB   = 10'b00_1000_0000,
    S_WR   = 10'b01_0000_0000,
    S_OUT  = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic signed [ffd_pkg::DMS_W-1:0]  dms_r;
  logic [ffd_pkg::SPM_W-1:0]         spm_r;
  logic [LW-1:0]                     len_r;
  logic signed [ffd_pkg::GAIN_W-1:0] gcfg_r;
  logic                              dsel_r;
  logic                              fsel_r;
  logic [AW-1:0]                     w_r;

  // per-sample datapath
  logic signed [ffd_pkg::D_W-1:0]    d_r;
  logic signed [SW-1:0]              x_r;
  logic signed [ffd_pkg::GAIN_W-1:0] gain_r;
  logic [LW-1:0]                     k_r;
  logic [ffd_pkg::FRAC_W-1:0]        f_r;
  logic [AW-1:0]                     idx2_r;
  logic signed [SW-1:0]              a_r;
  logic signed [PW-1:0]              prod_r;
  logic signed [SW-1:0]              y_r;
  logic signed [GPW-1:0]             fbp_r;
  logic                              out_valid_r;
  logic signed [SW-1:0]              out_sample_r;

  logic                              clamp;
  logic signed [ffd_pkg::DMS_W-1:0]  ms_sel;
  logic [ffd_pkg::LEN_CFG_W-1:0]     len_raw;
  logic [LW-1:0]                     len_new;
  logic [ffd_pkg::HI_W-1:0]          hi;
  logic [ffd_pkg::FRAC_W-1:0]        lo;
  logic                              d_neg;
  logic [ffd_pkg::HI_W-1:0]          hi_mag;
  logic [LW-1:0]                     k_clamp;
  logic [ffd_pkg::FRAC_W-1:0]        f_clamp;
  logic [LW-1:0]                     k_wrap;
  logic [ffd_pkg::FRAC_W-1:0]        f_wrap;
  logic [LW-1:0]                     m_wrap;
  logic [LW:0]                       tap_diff;
  logic [LW:0]                       tap_sum;
  logic [AW-1:0]                     idx_c;
  logic [LW-1:0]                     idx_p1;
  logic [AW-1:0]                     idx2_c;
  logic signed [SW:0]                diff_ab;
  logic signed [PW-1:0]              rnd;
  logic signed [SW+1:0]              y_sum;
  logic signed [GPW-1:0]             fbp_adj;
  logic signed [GPW-ffd_pkg::GAIN_FRAC-1:0] fb;
  logic signed [GPW-ffd_pkg::GAIN_FRAC:0]   mix;
  logic signed [SW-1:0]              mix_sat;
  logic [LW-1:0]                     w_p1;

  logic                              div_start;
  logic                              div_done;
  logic [LW-1:0]                     div_rem;
  logic [AW-1:0]                     mem_raddr;
  logic signed [SW-1:0]              mem_rdata;
  logic                              mem_we;

  assign clamp  = dsel_r && !fsel_r;
  assign ms_sel = dsel_r ? in_delay_ms_in : dms_r;

  // ---------------- configuration port ----------------
  always_comb begin
    len_raw = cfg_wdata[ffd_pkg::LEN_CFG_W-1:0];
    if (len_raw == '0) begin
      len_new = LW'(1);
    end else if (32'(len_raw) > 32'(MAX_DELAY)) begin
      len_new = LW'(MAX_DELAY);
    end else begin
      len_new = LW'(len_raw);
    end
  end

  always_comb begin
    w_p1 = LW'(w_r) + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dms_r  <= '0;
      spm_r  <= ffd_pkg::SPM_RST;
      len_r  <= LW'(LEN_RST);
      gcfg_r <= '0;
      dsel_r <= 1'b0;
      fsel_r <= 1'b0;
      w_r    <= '0;
    end else begin
      if (mem_we) begin
        w_r <= (w_p1 >= len_r) ? '0 : AW'(w_p1);
      end
      if (cfg_wr_en) begin
        case (cfg_addr)
          ffd_pkg::REG_DELAY_MS:  dms_r  <= $signed(cfg_wdata[ffd_pkg::DMS_W-1:0]);
          ffd_pkg::REG_SPM:       spm_r  <= cfg_wdata[ffd_pkg::SPM_W-1:0];
          ffd_pkg::REG_LENGTH: begin
            len_r <= len_new;
            w_r   <= '0;
          end
          ffd_pkg::REG_GAIN:      gcfg_r <= $signed(cfg_wdata[ffd_pkg::GAIN_W-1:0]);
          ffd_pkg::REG_DELAY_SEL: dsel_r <= cfg_wdata[0];
          ffd_pkg::REG_FB_SEL:    fsel_r <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  // ---------------- delay to tap distance ----------------
  always_comb begin
    hi     = d_r[ffd_pkg::D_W-1:ffd_pkg::FRAC_W];
    lo     = d_r[ffd_pkg::FRAC_W-1:0];
    d_neg  = d_r[ffd_pkg::D_W-1];
    hi_mag = d_neg ? (~hi + 1'b1) : hi;

    if (d_neg) begin
      k_clamp = '0;
      f_clamp = '0;
    end else if (hi >= ffd_pkg::HI_W'(len_r)) begin
      k_clamp = len_r - 1'b1;
      f_clamp = '0;
    end else begin
      k_clamp = LW'(hi);
      f_clamp = lo;
    end

    // floor(d / 2^16) mod L, then positive multiples of L land on L
    if (d_neg) begin
      m_wrap = (div_rem == '0) ? '0 : len_r - div_rem;
    end else begin
      m_wrap = div_rem;
    end
    if (!d_neg && (d_r != '0) && (m_wrap == '0) && (lo == '0)) begin
      k_wrap = len_r;
      f_wrap = '0;
    end else begin
      k_wrap = m_wrap;
      f_wrap = lo;
    end
  end

  assign div_start = (state_r == S_DLY) && !clamp;

  ffd_rem #(
    .LW (LW)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (hi_mag),
    .divisor  (len_r),
    .done     (div_done),
    .rem      (div_rem)
  );

  // ---------------- tap addresses ----------------
  always_comb begin
    tap_diff = {1'b0, LW'(w_r)} - {1'b0, k_r};
    tap_sum  = tap_diff + {1'b0, len_r};
    idx_c    = tap_diff[LW] ? AW'(tap_sum) : AW'(tap_diff);
    idx_p1   = LW'(idx_c) + 1'b1;
    idx2_c   = (idx_p1 == len_r) ? '0 : AW'(idx_p1);
  end

  assign mem_raddr = (state_r == S_RDB) ? idx2_r : idx_c;
  assign mem_we    = (state_r == S_WR);

  ffd_mem #(
    .DEPTH (MAX_DELAY),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata),
    .wr_en   (mem_we),
    .wr_addr (w_r),
    .wr_data (mix_sat)
  );

  // ---------------- interpolation and feedback ----------------
  always_comb begin
    diff_ab = $signed({mem_rdata[SW-1], mem_rdata}) - $signed({a_r[SW-1], a_r});
    // round half up, then floor
    rnd     = prod_r + PW'(32768);
    y_sum   = $signed({{2{a_r[SW-1]}}, a_r}) + $signed(rnd[PW-1:ffd_pkg::FRAC_W]);
    // gain scaling truncates toward zero
    fbp_adj = fbp_r[GPW-1] ? fbp_r + GPW'((1 << ffd_pkg::GAIN_FRAC) - 1) : fbp_r;
    fb      = fbp_adj[GPW-1:ffd_pkg::GAIN_FRAC];
    mix     = $signed({{(GPW - ffd_pkg::GAIN_FRAC - SW + 1){x_r[SW-1]}}, x_r})
            + $signed({fb[GPW-ffd_pkg::GAIN_FRAC-1], fb});
    if (mix > $signed({{(GPW - ffd_pkg::GAIN_FRAC - SW + 2){1'b0}}, {(SW-1){1'b1}}})) begin
      mix_sat = {1'b0, {(SW-1){1'b1}}};
    end else if (mix < $signed({{(GPW - ffd_pkg::GAIN_FRAC - SW + 2){1'b1}}, {(SW-1){1'b0}}}))
    begin
      mix_sat = {1'b1, {(SW-1){1'b0}}};
    end else begin
      mix_sat = mix[SW-1:0];
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_DLY;
      S_DLY:  state_nxt = clamp ? S_ADR : S_DIV;
      S_DIV:  if (div_done) state_nxt = S_ADR;
      S_ADR:  state_nxt = S_RDB;
      S_RDB:  state_nxt = S_INT;
      S_INT:  state_nxt = S_MIX;
      S_MIX:  state_nxt = S_FB;
      S_FB:   state_nxt = S_WR;
      S_WR:   state_nxt = S_OUT;
      S_OUT:  if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_OUT && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          d_r    <= ffd_pkg::D_W'($signed(ms_sel) * $signed({1'b0, spm_r}));
          x_r    <= in_sample;
          gain_r <= fsel_r ? in_feedback_in : gcfg_r;
        end
      end
      S_DLY: begin
        if (clamp) begin
          k_r <= k_clamp;
          f_r <= f_clamp;
        end
      end
      S_DIV: begin
        if (div_done) begin
          k_r <= k_wrap;
          f_r <= f_wrap;
        end
      end
      S_ADR: idx2_r <= idx2_c;
      S_RDB: a_r <= mem_rdata;
      S_INT: prod_r <= PW'($signed({1'b0, f_r}) * diff_ab);
      S_MIX: y_r <= y_sum[SW-1:0];
      S_FB:  fbp_r <= y_r * gain_r;
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_sample_r <= y_r;
        end
      end
      default: ;
    endcase
  end

  assign in_stall   = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

  // in_block_end only marks host vector boundaries and does not affect the beat

  // ---------------- checks ----------------
  a_windex_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    LW'(w_r) < len_r)
    else $error("write index outside active length");

  a_one_write_per_beat: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> !mem_we)
    else $error("delay memory written twice for one beat");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result raised outside output step");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_DLY))
    else $error("accepted beat did not start the sequencer");

  a_tap_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADR) |-> (k_r <= len_r))
    else $error("tap distance beyond active length");

endmodule

// ===== verif/fractional_feedback_delay_core_tb.sv =====
`timescale 1ns / 1ps

module fractional_feedback_delay_core_tb;

  localparam int LINE_MAX       = 65536;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 40;
  localparam int RAND_PHASES    = 20;
  localparam int PHASE_ITEMS    = 100;

  logic                                clk;
  logic                                rst_n;
  logic                                in_valid;
  logic                                in_stall;
  logic signed [ffd_pkg::SAMPLE_W-1:0] in_sample;
  logic signed [ffd_pkg::DMS_W-1:0]    in_delay_ms_in;
  logic signed [ffd_pkg::GAIN_W-1:0]   in_feedback_in;
  logic                                in_block_end;
  logic                                out_valid;
  logic                                out_stall;
  logic signed [ffd_pkg::SAMPLE_W-1:0] out_sample;
  logic                                cfg_wr_en;
  logic [ffd_pkg::CFG_AW-1:0]          cfg_addr;
  logic [ffd_pkg::CFG_DW-1:0]          cfg_wdata;

  fractional_feedback_delay_core #(
    .MAX_DELAY(LINE_MAX)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample     (in_sample),
    .in_delay_ms_in(in_delay_ms_in),
    .in_feedback_in(in_feedback_in),
    .in_block_end  (in_block_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sample    (out_sample),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  // shadow of the delay line and its registers
  logic signed [ffd_pkg::SAMPLE_W-1:0] line_mem [0:LINE_MAX-1];
  longint wr_ptr     = 0;
  longint dly_ms_reg = 0;
  longint spm_reg    = ffd_pkg::SPM_RST;
  longint len_reg    = LINE_MAX;
  longint gain_reg   = 0;
  bit     dly_sel    = 1'b0;
  bit     fb_sel     = 1'b0;

  logic signed [ffd_pkg::SAMPLE_W-1:0] expected_taps [$];
  int samples_sent  = 0;
  int results_seen  = 0;
  int fail_count    = 0;
  int idle_cycles   = 0;
  bit send_gaps_on  = 1'b1;
  bit stall_gaps_on = 1'b1;
  int hold_len      = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void apply_cfg(input logic [ffd_pkg::CFG_AW-1:0] idx,
                                    input logic [ffd_pkg::CFG_DW-1:0] val);
    longint v;
    case (idx)
      ffd_pkg::REG_DELAY_MS:  dly_ms_reg = longint'(signed'(val[ffd_pkg::DMS_W-1:0]));
      ffd_pkg::REG_SPM:       spm_reg = val[ffd_pkg::SPM_W-1:0];
      ffd_pkg::REG_LENGTH: begin
        v = val[ffd_pkg::LEN_CFG_W-1:0];
        if (v == 0) v = 1;
        if (v > LINE_MAX) v = LINE_MAX;
        len_reg = v;
        wr_ptr = 0;
      end
      ffd_pkg::REG_GAIN:      gain_reg = longint'(signed'(val[ffd_pkg::GAIN_W-1:0]));
      ffd_pkg::REG_DELAY_SEL: dly_sel = val[0];
      ffd_pkg::REG_FB_SEL:    fb_sel = val[0];
      default: ;
    endcase
  endfunction

  // read the interpolated tap, write back input plus scaled tap, advance
  function automatic logic signed [ffd_pkg::SAMPLE_W-1:0] delay_line_step(
    input logic signed [ffd_pkg::SAMPLE_W-1:0] x,
    input logic signed [ffd_pkg::DMS_W-1:0]    dms,
    input logic signed [ffd_pkg::GAIN_W-1:0]   fbk
  );
    longint ms, gain, span, d, k, f, rd, rd2, a, b, y, fb, sum, w;
    ms   = dly_sel ? longint'(dms) : dly_ms_reg;
    gain = fb_sel ? longint'(fbk) : gain_reg;
    span = len_reg * 65536;
    d    = ms * spm_reg;
    w    = wr_ptr;
    if (w >= len_reg) w = 0;
    if (dly_sel && !fb_sel) begin
      if (d < 0) d = 0;
      else if (d >= span) d = (len_reg - 1) * 65536;
    end else if (d > 0) begin
      d = d % span;
      if (d == 0) d = span;
    end else if (d < 0) begin
      d = ((d % span) + span) % span;
    end
    k   = d >>> ffd_pkg::FRAC_W;
    f   = d & 65535;
    rd  = w - k;
    if (rd < 0) rd += len_reg;
    rd2 = rd + 1;
    if (rd2 >= len_reg) rd2 = 0;
    a   = line_mem[rd];
    b   = line_mem[rd2];
    y   = a + ((f * (b - a) + 32768) >>> 16);
    fb  = (y * gain) / 16384;
    sum = longint'(x) + fb;
    if (sum > 8388607) sum = 8388607;
    if (sum < -8388608) sum = -8388608;
    line_mem[w] = sum[ffd_pkg::SAMPLE_W-1:0];
    w++;
    if (w >= len_reg) w = 0;
    wr_ptr = w;
    return y[ffd_pkg::SAMPLE_W-1:0];
  endfunction

  // monitor: config writes, input beats, result beats, watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr_en) apply_cfg(cfg_addr, cfg_wdata);
      if (in_valid && !in_stall)
        expected_taps.push_back(delay_line_step(in_sample, in_delay_ms_in, in_feedback_in));
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_taps.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected out beat: out_sample=%0d", out_sample);
        end else begin
          if (out_sample !== expected_taps[0]) begin
            fail_count++;
            if (fail_count <= 10)
              $display("out_sample mismatch at beat %0d: expected %0d, got %0d",
                       results_seen, expected_taps[0], out_sample);
          end
          void'(expected_taps.pop_front());
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("fractional_feedback_delay_core_tb: done, errors");
        $finish;
      end
    end
  end

  // result side: per-beat random stall, or one long hold-off on request
  initial begin
    int w;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_len > 0) begin
        w = hold_len;
        hold_len = 0;
      end else begin
        w = stall_gaps_on ? $urandom_range(0, 11) : 0;
      end
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // valid stays high after the beat so back-to-back samples need no dip
  task automatic send_sample(input longint x, input longint dms, input longint fbk,
                             input bit tag);
    int gap;
    gap = send_gaps_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_sample      <= x[ffd_pkg::SAMPLE_W-1:0];
    in_delay_ms_in <= dms[ffd_pkg::DMS_W-1:0];
    in_feedback_in <= fbk[ffd_pkg::GAIN_W-1:0];
    in_block_end   <= tag;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    samples_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (results_seen != samples_sent) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [ffd_pkg::CFG_AW-1:0] idx, input longint val);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val[ffd_pkg::CFG_DW-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_mode(input longint len_raw, input longint spm, input longint dms,
                          input longint gain, input bit dsel, input bit fsel);
    wait_idle();
    cfg_write(ffd_pkg::REG_DELAY_MS, dms);
    cfg_write(ffd_pkg::REG_SPM, spm);
    cfg_write(ffd_pkg::REG_LENGTH, len_raw);
    cfg_write(ffd_pkg::REG_GAIN, gain);
    cfg_write(ffd_pkg::REG_DELAY_SEL, dsel);
    cfg_write(ffd_pkg::REG_FB_SEL, fsel);
  endtask

  // delays mostly within a little over the line, some negative, some anything
  function automatic longint pick_delay_ms(input longint len, input longint spm);
    longint lim;
    longint t;
    if (spm == 0) lim = 8388607;
    else lim = (len * 81920) / spm + 1;
    if (lim > 8388607) lim = 8388607;
    t = $urandom_range(0, int'(lim));
    case ($urandom_range(0, 9))
      0:       return longint'(signed'(ffd_pkg::DMS_W'($urandom)));
      1:       return -t;
      default: return t;
    endcase
  endfunction

  function automatic longint pick_sample();
    case ($urandom_range(0, 9))
      0:       return 8388607;
      1:       return -8388608;
      2:       return longint'($urandom_range(0, 2000)) - 1000;
      default: return longint'(signed'(ffd_pkg::SAMPLE_W'($urandom)));
    endcase
  endfunction

  function automatic longint pick_gain();
    case ($urandom_range(0, 9))
      0:       return -32768;
      1:       return 32767;
      2, 3, 4: return longint'(signed'(ffd_pkg::GAIN_W'($urandom)));
      default: return longint'($urandom_range(0, 32767)) - 16384;
    endcase
  endfunction

  task automatic test_reset_state();
    send_sample(1000, 0, 0, 1'b0);
    send_sample(-1000, 0, 0, 1'b1);
  endtask

  // gain near 2 drives the stored value into both rails
  task automatic test_saturation();
    set_mode(4, 256, 384, 32767, 1'b0, 1'b0);
    send_sample(8388607, 0, 0, 1'b0);
    send_sample(8388607, 0, 0, 1'b0);
    send_sample(-8388608, 0, 0, 1'b1);
    send_sample(-8388608, 0, 0, 1'b0);
    send_sample(8388607, 0, 0, 1'b0);
    send_sample(1, 0, 0, 1'b0);
    send_sample(-1, 0, 0, 1'b1);
  endtask

  // 1024 ms at 1/256 sample per ms is exactly the line length of 4
  task automatic test_delay_wrap();
    set_mode(4, 256, 0, 0, 1'b1, 1'b1);
    send_sample(4000000, 8388607, 32767, 1'b0);
    send_sample(-4000000, -8388608, -32768, 1'b1);
    send_sample(123456, 0, 16384, 1'b0);
    send_sample(-7, 1024, -16384, 1'b0);
    send_sample(8388607, -1024, 32767, 1'b1);
    send_sample(-8388608, 640, 0, 1'b0);
  endtask

  task automatic test_delay_clamp();
    set_mode(4, 256, 0, -16384, 1'b1, 1'b0);
    send_sample(3000000, -256, 0, 1'b0);
    send_sample(-2000000, 0, 0, 1'b1);
    send_sample(777777, 8388607, 0, 1'b0);
    send_sample(-5, 768, 0, 1'b1);
    send_sample(8388607, 1024, 0, 1'b0);
    send_sample(-8388608, 640, 0, 1'b1);
  endtask

  // length 0 acts as 1, anything above the max acts as the max
  task automatic test_length_limits();
    set_mode(0, 65535, 8388607, 16383, 1'b0, 1'b0);
    send_sample(5000000, 0, 0, 1'b0);
    send_sample(-6000000, 0, 0, 1'b1);
    set_mode(131071, 0, -8388608, 0, 1'b0, 1'b1);
    send_sample(2345678, 0, -32768, 1'b0);
    send_sample(-8388608, 0, 32767, 1'b1);
  endtask

  task automatic test_random_traffic();
    longint len_raw, len_eff, spm;
    for (int p = 0; p < RAND_PHASES; p++) begin
      case ($urandom_range(0, 9))
        0:       len_raw = 0;
        1:       len_raw = $urandom_range(65537, 131071);
        2:       len_raw = 65536;
        3:       len_raw = $urandom_range(65, 4096);
        4:       len_raw = $urandom_range(1, 2);
        default: len_raw = $urandom_range(2, 64);
      endcase
      len_eff = (len_raw == 0) ? 1 : ((len_raw > LINE_MAX) ? LINE_MAX : len_raw);
      case ($urandom_range(0, 9))
        0:       spm = 0;
        1:       spm = 65535;
        2:       spm = ffd_pkg::SPM_RST;
        3, 4:    spm = $urandom_range(0, 65535);
        default: spm = $urandom_range(64, 1024);
      endcase
      set_mode(len_raw, spm, pick_delay_ms(len_eff, spm), pick_gain(),
               $urandom_range(0, 1), $urandom_range(0, 1));
      send_gaps_on  = ($urandom_range(0, 3) != 0);
      stall_gaps_on = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_sample(pick_sample(), pick_delay_ms(len_eff, spm), pick_gain(),
                    $urandom_range(0, 1));
    end
  endtask

  // receiver goes quiet while samples keep coming, so the input must stall
  task automatic test_output_backpressure();
    set_mode(16, 256, 2000, 12000, 1'b0, 1'b1);
    send_gaps_on  = 1'b0;
    stall_gaps_on = 1'b1;
    hold_len      = HOLD_CYCLES;
    for (int i = 0; i < 30; i++)
      send_sample(pick_sample(), pick_delay_ms(16, 256), pick_gain(), $urandom_range(0, 1));
    send_gaps_on = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < LINE_MAX; i++) line_mem[i] = '0;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_sample      <= '0;
    in_delay_ms_in <= '0;
    in_feedback_in <= '0;
    in_block_end   <= 1'b0;
    cfg_wr_en      <= 1'b0;
    cfg_addr       <= '0;
    cfg_wdata      <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_saturation();
    test_delay_wrap();
    test_delay_clamp();
    test_length_limits();
    test_random_traffic();
    test_output_backpressure();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_taps.size() == 0)
      $display("fractional_feedback_delay_core_tb: done, clean");
    else
      $display("fractional_feedback_delay_core_tb: done, errors");
    $finish;
  end

endmodule
